>>> hdl/lpr_pkg.sv
// Shared types for the LRU page frame replacer.
// No dependencies; used by lpr_cell, lru_page_frame_replacer and lpr_checker.
package lpr_pkg;

  localparam int CFG_W    = 5;
  localparam int IN_PAGE_W = 16;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 32;

  // Per-cycle command broadcast to every cell of the frame chain.
  typedef struct packed {
    logic lookup;     // compare probe page, pick hit or empty frame
    logic step;       // one bit of the LRU victim search
    logic evict;      // chosen frame comes from the victim search
    logic commit;     // apply the recency update
    logic load;       // write probe page into the chosen frame
    logic unbounded;  // every valid frame ages (fill of an empty frame)
  } lpr_ctl_t;

endpackage

>>> hdl/lpr_cell.sv
// One frame of the replacer: page tag, valid bit and recency rank.
// Depends on lpr_pkg; chained by lru_page_frame_replacer.
module lpr_cell #(
  parameter int PW = 16,
  parameter int RW = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lpr_pkg::lpr_ctl_t ctl,
  input  logic             act,
  input  logic [PW-1:0]    probe_page,
  input  logic [RW-1:0]    limit,
  input  logic [RW-1:0]    bit_mask,
  input  logic             hit_any,
  input  logic             empty_any,
  input  logic             bit_any,
  input  logic             hit_in,
  input  logic             empty_in,
  input  logic             bit_in,
  output logic             hit_out,
  output logic             empty_out,
  output logic             bit_out,
  output logic             chosen,
  output logic [PW-1:0]    page,
  output logic [RW-1:0]    rank
);
  import lpr_pkg::*;

  logic [PW-1:0] page_r;
  logic          valid_r;
  logic [RW-1:0] rank_r;
  logic          sel_r;
  logic          cand_r;

  logic match;
  logic empty;
  logic bitv;

  assign match     = valid_r & act & (page_r == probe_page);
  assign empty     = act & ~valid_r;
  assign bitv      = cand_r & (|(rank_r & bit_mask));
  assign hit_out   = hit_in | match;
  assign empty_out = empty_in | empty;
  assign bit_out   = bit_in | bitv;
  assign chosen    = ctl.evict ? cand_r : sel_r;
  assign page      = page_r;
  assign rank      = rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      sel_r   <= 1'b0;
      cand_r  <= 1'b0;
    end else begin
      if (ctl.lookup) begin
        sel_r  <= (match & ~hit_in) | (~hit_any & empty_any & empty & ~empty_in);
        cand_r <= act & valid_r;
      end
      if (ctl.step && bit_any) begin
        cand_r <= bitv;
      end
      if (ctl.commit) begin
        if (chosen) begin
          rank_r <= '0;
          if (ctl.load) begin
            valid_r <= 1'b1;
          end
        end else if (valid_r && (ctl.unbounded || rank_r < limit)) begin
          rank_r <= rank_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && chosen && ctl.load) begin
      page_r <= probe_page;
    end
  end

endmodule

>>> hdl/lru_page_frame_replacer.sv
// LRU page frame replacer: top level, control sequencer and chain of frame cells.
// Depends on lpr_pkg and lpr_cell.
//
// Usage: one page reference per input item (in_valid/in_ready). Each item yields
// exactly one result item (out_valid/out_ready): fault flag, frame that now holds
// the page, evicted page if any, and the saturating fault total.
// cfg_we/cfg_wdata set the number of active frames (0 acts as 1, above FRAMES as
// FRAMES); write it only while no item is in flight.
// A hit or a fill of an empty frame goes from accept straight to the commit
// state, which loads the result into the output register. A replacement adds
// the LRU victim search, one rank bit per cycle across the cell chain, between
// accept and commit.
// One item is in flight at a time; in_ready is high whenever the sequencer is
// idle, even while a result waits in the output register.
// A stalled receiver holds the result; the next item then waits at commit.
// Reset empties all frames, clears the fault count and sets the frame count to 16.
module lru_page_frame_replacer #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lpr_pkg::IN_PAGE_W-1:0]    in_page_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_page_fault,
  output logic [lpr_pkg::SLOT_W-1:0]       out_frame_slot,
  output logic                             out_evicted_valid,
  output logic [lpr_pkg::IN_PAGE_W-1:0]    out_evicted_page,
  output logic [lpr_pkg::COUNT_W-1:0]      out_fault_total
);
  import lpr_pkg::*;

  localparam int PW = PAGE_BITS;
  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AW = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT} state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r, cfg_nxt;
  logic [PW-1:0]        page_r, page_nxt;
  logic                 hit_r, hit_nxt;
  logic                 fill_r, fill_nxt;
  logic                 evict_r, evict_nxt;
  logic [RW-1:0]        mask_r, mask_nxt;
  logic [COUNT_W-1:0]   fault_cnt_r, fault_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 fault_r, fault_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [IN_PAGE_W-1:0] ev_page_r, ev_page_nxt;

  lpr_ctl_t             ctl;
  logic [AW-1:0]        active_cnt;
  logic [FRAMES-1:0]    act;
  logic [PW-1:0]        probe_page;
  logic [FRAMES:0]      hit_c, empty_c, bit_c;
  logic [FRAMES-1:0]    chosen;
  logic [PW-1:0]        cell_page [FRAMES];
  logic [RW-1:0]        cell_rank [FRAMES];
  logic [RW-1:0]        limit;
  logic [PW-1:0]        sel_page;
  logic [SW-1:0]        sel_idx;
  logic                 accept;
  logic                 commit;

  always_comb begin
    if (cfg_r == '0) begin
      active_cnt = AW'(1);
    end else if (AW'(cfg_r) > AW'(FRAMES)) begin
      active_cnt = AW'(FRAMES);
    end else begin
      active_cnt = AW'(cfg_r);
    end
    for (int i = 0; i < FRAMES; i++) begin
      act[i] = (AW'(i) < active_cnt);
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid & in_ready;
  assign commit     = (state_r == S_COMMIT) & (~out_valid_r | out_ready);
  assign probe_page = (state_r == S_IDLE) ? PW'(in_page_number) : page_r;

  always_comb begin
    ctl.lookup    = accept;
    ctl.step      = (state_r == S_SEARCH);
    ctl.evict     = evict_r;
    ctl.commit    = commit;
    ctl.load      = ~hit_r;
    ctl.unbounded = fill_r;
  end

  assign hit_c[0]   = 1'b0;
  assign empty_c[0] = 1'b0;
  assign bit_c[0]   = 1'b0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell #(
      .PW(PW),
      .RW(RW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .act       (act[g]),
      .probe_page(probe_page),
      .limit     (limit),
      .bit_mask  (mask_r),
      .hit_any   (hit_c[FRAMES]),
      .empty_any (empty_c[FRAMES]),
      .bit_any   (bit_c[FRAMES]),
      .hit_in    (hit_c[g]),
      .empty_in  (empty_c[g]),
      .bit_in    (bit_c[g]),
      .hit_out   (hit_c[g+1]),
      .empty_out (empty_c[g+1]),
      .bit_out   (bit_c[g+1]),
      .chosen    (chosen[g]),
      .page      (cell_page[g]),
      .rank      (cell_rank[g])
    );
  end

  // chosen is one-hot at commit
  always_comb begin
    limit    = '0;
    sel_page = '0;
    sel_idx  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (chosen[i]) begin
        limit    = limit | cell_rank[i];
        sel_page = sel_page | cell_page[i];
        sel_idx  = sel_idx | SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_we ? cfg_wdata : cfg_r;
    page_nxt      = page_r;
    hit_nxt       = hit_r;
    fill_nxt      = fill_r;
    evict_nxt     = evict_r;
    mask_nxt      = mask_r;
    fault_cnt_nxt = fault_cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    fault_nxt     = fault_r;
    slot_nxt      = slot_r;
    ev_valid_nxt  = ev_valid_r;
    ev_page_nxt   = ev_page_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          page_nxt  = PW'(in_page_number);
          hit_nxt   = hit_c[FRAMES];
          fill_nxt  = ~hit_c[FRAMES] & empty_c[FRAMES];
          evict_nxt = ~hit_c[FRAMES] & ~empty_c[FRAMES];
          mask_nxt  = RW'(1) << (RW - 1);
          state_nxt = (hit_c[FRAMES] | empty_c[FRAMES]) ? S_COMMIT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        mask_nxt = mask_r >> 1;
        if (mask_r[0]) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          fault_nxt     = ~hit_r;
          slot_nxt      = SLOT_W'(sel_idx);
          ev_valid_nxt  = evict_r;
          ev_page_nxt   = evict_r ? IN_PAGE_W'(sel_page) : '0;
          if (!hit_r && fault_cnt_r != '1) begin
            fault_cnt_nxt = fault_cnt_r + COUNT_W'(1);
          end
          evict_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(16);
      evict_r     <= 1'b0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      evict_r     <= evict_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r     <= page_nxt;
    hit_r      <= hit_nxt;
    fill_r     <= fill_nxt;
    mask_r     <= mask_nxt;
    fault_r    <= fault_nxt;
    slot_r     <= slot_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_page_fault    = fault_r;
  assign out_frame_slot    = slot_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;
  assign out_fault_total   = fault_cnt_r;

endmodule

>>> hdl/lpr_checker.sv
// Port-level checks for lru_page_frame_replacer, attached by bind.
// Depends on lpr_pkg for field widths.
module lpr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_page_fault,
  input logic [lpr_pkg::SLOT_W-1:0]    out_frame_slot,
  input logic                          out_evicted_valid,
  input logic [lpr_pkg::IN_PAGE_W-1:0] out_evicted_page,
  input logic [lpr_pkg::COUNT_W-1:0]   out_fault_total
);
  import lpr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_slot)
      && $stable(out_evicted_page) && $stable(out_page_fault))
    else $error("result item changed while stalled");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> out_page_fault)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_fault_total >= $past(out_fault_total))
    else $error("fault total decreased");

endmodule

bind lru_page_frame_replacer lpr_checker u_lpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_page_fault   (out_page_fault),
  .out_frame_slot   (out_frame_slot),
  .out_evicted_valid(out_evicted_valid),
  .out_evicted_page (out_evicted_page),
  .out_fault_total  (out_fault_total)
);
